/* src/four_mode_waveform_generator_unit_assert.svh */
// Assertion macros used by the waveform generator top level.
`ifndef FOUR_MODE_WAVEFORM_GENERATOR_UNIT_ASSERT_SVH
`define FOUR_MODE_WAVEFORM_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FMWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fmwg_pkg.sv */
`default_nettype none

package fmwg_pkg;

	// Wave type codes held in the wave type register.
	localparam logic [2:0] WAVE_NONE     = 3'd0;
	localparam logic [2:0] WAVE_RAMP     = 3'd1;
	localparam logic [2:0] WAVE_SQUARE   = 3'd2;
	localparam logic [2:0] WAVE_SINE     = 3'd3;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_WAVE_TYPE = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE = 2'd1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int AMP_W       = 16;
	localparam int WORD_W      = 14;
	localparam int LEVEL_W     = 32;
	localparam int SINE_W      = 17;
	localparam int SINE_MAG_W  = 16;

	localparam logic [31:0] RAMP_STEP     = 32'd450;
	localparam logic [31:0] TRIANGLE_STEP = 32'd50;
	localparam logic [16:0] SINE_MID      = 17'd32768;

	// Pi and one in Q28, used only when the sine table is built.
	localparam logic [63:0] PI_Q28      = 64'd843314857;
	localparam logic [63:0] HALF_PI_Q28 = PI_Q28 / 64'd2;
	localparam logic [63:0] ONE_Q28     = 64'd268435456;

	// Control handed from the top level to the waveform state.
	typedef struct packed {
		logic                advance;
		logic [2:0]          wave_type;
		logic [AMP_W-1:0]    amplitude;
	} fmwg_ctrl_t;

	// Magnitude of the sine of a Q28 angle, in Q15, capped at one. It is only
	// evaluated at elaboration to fill the sine table.
	function automatic logic [SINE_MAG_W-1:0] sine_mag(input logic [63:0] angle);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] q;
		a = angle;
		if (a > PI_Q28) begin
			a = PI_Q28;
		end
		if (a > HALF_PI_Q28) begin
			a = PI_Q28 - a;
		end
		x2 = (a * a) >> 28;
		t  = ONE_Q28 - x2 / 64'd72;
		t  = ONE_Q28 - ((x2 * t) >> 28) / 64'd42;
		t  = ONE_Q28 - ((x2 * t) >> 28) / 64'd20;
		t  = ONE_Q28 - ((x2 * t) >> 28) / 64'd6;
		s  = (a * t) >> 28;
		q  = (s + 64'd4096) >> 13;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[SINE_MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/fmwg_sine_rom.sv */
`default_nettype none

// Constant sine magnitude table with a registered read port.
module fmwg_sine_rom #(
	parameter int STEPS_PER_RADIAN = 100,
	parameter int PHASE_LIMIT      = 314,
	localparam int AW              = $clog2(PHASE_LIMIT + 1)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [AW-1:0]                      addr,
	output logic      [fmwg_pkg::SINE_MAG_W-1:0]    data
);

	logic [fmwg_pkg::SINE_MAG_W-1:0] sine_w [0:PHASE_LIMIT];
	logic [fmwg_pkg::SINE_MAG_W-1:0] data_q;

	for (genvar g = 0; g <= PHASE_LIMIT; g++) begin : g_entry
		localparam logic [63:0] ANGLE = (64'(g) << 28) / 64'(STEPS_PER_RADIAN);
		assign sine_w[g] = fmwg_pkg::sine_mag(ANGLE);
	end

	// The entry for phase zero is zero, which matches the phase after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= sine_w[addr];
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

/* src/fmwg_wave_step.sv */
`default_nettype none

// Waveform state and its one-step update.
module fmwg_wave_step #(
	parameter int PHASE_LIMIT = 314,
	localparam int AW         = $clog2(PHASE_LIMIT + 1)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fmwg_pkg::fmwg_ctrl_t               ctrl,
	input  wire logic [fmwg_pkg::SINE_MAG_W-1:0]    rom_data,
	output logic      [AW-1:0]                      rom_addr,
	output logic      [fmwg_pkg::LEVEL_W-1:0]       level_next
);

	localparam int PW = $clog2(PHASE_LIMIT + 2) + 1;
	localparam logic signed [PW-1:0] LIMIT_S     = PW'(PHASE_LIMIT);
	localparam logic signed [PW-1:0] NEG_LIMIT_S = PW'(-PHASE_LIMIT);
	localparam logic [PW-1:0]        LIMIT_U     = PW'(PHASE_LIMIT);

	logic signed [PW-1:0]              phase_q;
	logic signed [PW-1:0]              phase_d;
	logic [PW-1:0]                     phase_mag;
	logic [fmwg_pkg::SINE_W-1:0]       sine_q;
	logic [fmwg_pkg::SINE_W-1:0]       sine_d;
	logic [fmwg_pkg::LEVEL_W-1:0]      level_q;
	logic [fmwg_pkg::LEVEL_W-1:0]      level_d;
	logic                              dir_up_q;
	logic                              dir_d;
	logic [31:0]                       sine_prod;
	logic [fmwg_pkg::LEVEL_W-1:0]      tri_up;
	logic [fmwg_pkg::LEVEL_W-1:0]      tri_dn;
	logic                              in_range;

	assign in_range  = (phase_q <= LIMIT_S);
	assign tri_up    = level_q + fmwg_pkg::TRIANGLE_STEP;
	assign tri_dn    = level_q - fmwg_pkg::TRIANGLE_STEP;

	// The table word belongs to the current phase, so a new sample is ready now.
	always_comb begin
		if (in_range) begin
			if (phase_q[PW-1]) begin
				sine_d = fmwg_pkg::SINE_MID - {1'b0, rom_data};
			end else begin
				sine_d = fmwg_pkg::SINE_MID + {1'b0, rom_data};
			end
		end else begin
			sine_d = sine_q;
		end
	end

	assign sine_prod = {15'b0, sine_d} * {17'b0, ctrl.amplitude[fmwg_pkg::AMP_W-1:1]};

	always_comb begin
		level_d = level_q;
		dir_d   = dir_up_q;
		phase_d = phase_q;
		if (ctrl.advance) begin
			case (ctrl.wave_type)
				fmwg_pkg::WAVE_RAMP: begin
					level_d = level_q + fmwg_pkg::RAMP_STEP;
				end
				fmwg_pkg::WAVE_SQUARE: begin
					level_d = dir_up_q ? {16'b0, ctrl.amplitude} : '0;
					dir_d   = !dir_up_q;
				end
				fmwg_pkg::WAVE_SINE: begin
					phase_d = in_range ? phase_q + PW'(1) : NEG_LIMIT_S;
					level_d = {15'b0, sine_prod[31:15]};
				end
				fmwg_pkg::WAVE_TRIANGLE: begin
					if (!dir_up_q) begin
						level_d = tri_up;
						if ($signed(tri_up) >= $signed({16'b0, ctrl.amplitude})) begin
							dir_d = 1'b1;
						end
					end else begin
						level_d = tri_dn;
						if (tri_dn[31] || tri_dn == '0) begin
							dir_d = 1'b0;
						end
					end
				end
				default: begin
					level_d = level_q;
				end
			endcase
		end
	end

	// Look up the phase that will be current next cycle.
	assign phase_mag = phase_d[PW-1] ? PW'(-phase_d) : PW'(phase_d);
	assign rom_addr  = (phase_mag > LIMIT_U) ? AW'(PHASE_LIMIT) : phase_mag[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			dir_up_q <= 1'b0;
			phase_q  <= '0;
			sine_q   <= '0;
		end else begin
			level_q  <= level_d;
			dir_up_q <= dir_d;
			phase_q  <= phase_d;
			if (ctrl.advance && ctrl.wave_type == fmwg_pkg::WAVE_SINE) begin
				sine_q <= sine_d;
			end
		end
	end

	assign level_next = level_d;

endmodule

`default_nettype wire

/* src/four_mode_waveform_generator_unit.sv */
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    tick
// out       out        out_valid / out_ready  dac_word
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// One item is taken every clock cycle while in_ready is high; its word is registered in
// the output register, or the skid slot on a stall; the state update and buffer set the rate.
// Reset clears the waveform state, the registers and the output buffer.
// A stalled output fills a second buffer slot, after which in_ready drops.
`default_nettype none

`include "four_mode_waveform_generator_unit_assert.svh"

module four_mode_waveform_generator_unit #(
	parameter int DAC_BITS         = 14,
	parameter int STEPS_PER_RADIAN = 100
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 tick,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [fmwg_pkg::WORD_W-1:0]          dac_word,
	input  wire logic                                 cfg_we,
	input  wire logic [fmwg_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [fmwg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Largest phase index, floor(pi * STEPS_PER_RADIAN).
	localparam int PHASE_LIMIT = int'((64'(STEPS_PER_RADIAN) * 64'd314159265)
		/ 64'd100000000);
	localparam int AW = $clog2(PHASE_LIMIT + 1);
	localparam logic [31:0] DAC_MASK = 32'((64'd1 << DAC_BITS) - 64'd1);

	logic [2:0]                         wave_type_q;
	logic [fmwg_pkg::AMP_W-1:0]         amplitude_q;
	fmwg_pkg::fmwg_ctrl_t               ctrl;
	logic                               in_accept;
	logic                               out_fire;
	logic [AW-1:0]                      rom_addr;
	logic [fmwg_pkg::SINE_MAG_W-1:0]    rom_data;
	logic [fmwg_pkg::LEVEL_W-1:0]       level_next;
	logic [fmwg_pkg::WORD_W-1:0]        word_d;
	logic                               out_valid_q;
	logic                               skid_valid_q;
	logic [fmwg_pkg::WORD_W-1:0]        out_word_q;
	logic [fmwg_pkg::WORD_W-1:0]        skid_word_q;

	// Configuration writes land directly; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q <= fmwg_pkg::WAVE_NONE;
			amplitude_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fmwg_pkg::REG_WAVE_TYPE: wave_type_q <= cfg_data[2:0];
				fmwg_pkg::REG_AMPLITUDE: amplitude_q <= cfg_data;
				default: begin
					wave_type_q <= wave_type_q;
				end
			endcase
		end
	end

	// The input side stalls only once both buffer slots hold an item.
	assign in_ready  = !skid_valid_q;
	assign in_accept = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;

	// A tick-less item still yields the current word, so the state only
	// advances when the item carries a tick.
	assign ctrl.advance   = in_accept && tick;
	assign ctrl.wave_type = wave_type_q;
	assign ctrl.amplitude = amplitude_q;

	fmwg_wave_step #(
		.PHASE_LIMIT (PHASE_LIMIT)
	) u_wave_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.rom_data   (rom_data),
		.rom_addr   (rom_addr),
		.level_next (level_next)
	);

	fmwg_sine_rom #(
		.STEPS_PER_RADIAN (STEPS_PER_RADIAN),
		.PHASE_LIMIT      (PHASE_LIMIT)
	) u_sine_rom (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (rom_addr),
		.data   (rom_data)
	);

	// The word keeps the low DAC_BITS bits, at most WORD_W, of the level that results from this item.
	assign word_d = level_next[fmwg_pkg::WORD_W-1:0] & DAC_MASK[fmwg_pkg::WORD_W-1:0];

	// Two-slot output buffer: the output register and a skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_accept;
				end
			end else if (in_accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_word_q <= skid_word_q;
			end else if (in_accept) begin
				out_word_q <= word_d;
			end
		end else if (in_accept) begin
			skid_word_q <= word_d;
		end
	end

	assign out_valid = out_valid_q;
	assign dac_word  = out_word_q;

	// The skid slot is only ever filled behind a full output register.
	`FMWG_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid slot holds an item while the output register is empty")
	// An item accepted against a stalled output must land in the skid slot.
	`FMWG_ASSERT_NEXT(a_stall_to_skid, clk, arst_n, in_accept && out_valid_q && !out_ready, skid_valid_q, "item lost while the output stalled")
	// A square step presented straight away gives either zero or the amplitude.
	`FMWG_ASSERT_NEXT(a_square_levels, clk, arst_n, in_accept && tick && wave_type_q == fmwg_pkg::WAVE_SQUARE && cfg_we == 1'b0 && (!out_valid_q || out_ready), dac_word == '0 || dac_word == (amplitude_q[fmwg_pkg::WORD_W-1:0] & DAC_MASK[fmwg_pkg::WORD_W-1:0]), "square wave word is neither zero nor the amplitude")

endmodule

`default_nettype wire
